[rtl/miadj_pkg.sv]
// Shared types, sizes and index helpers for the 3x3 adjugate inverse unit.
// Depends on nothing; miadj_div and the top level import it, miadj_ram does not.
package miadj_pkg;

    localparam int DIM    = 3;
    localparam int NELEM  = DIM * DIM;
    localparam int ELEM_W = 16;
    localparam int FRAC_W = 16;
    localparam int ADJ_W  = 33;
    localparam int DET_W  = 50;
    localparam int OUT_W  = 49;
    localparam int IDX_W  = 4;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [1:0]       t_rc;

    function automatic t_idx f_addr(input t_rc row, input t_rc col);
        t_idx r4;
        r4 = {2'b00, row};
        return (r4 << 1) + r4 + {2'b00, col};
    endfunction

    function automatic t_rc f_lo(input t_rc x);
        return (x == 2'd0) ? 2'd1 : 2'd0;
    endfunction

    function automatic t_rc f_hi(input t_rc x);
        return (x == 2'd2) ? 2'd1 : 2'd2;
    endfunction

endpackage

[rtl/miadj_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module miadj_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 9
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/miadj_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on miadj_pkg for the operand widths.
module miadj_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [miadj_pkg::OUT_W-1:0]  i_num,
    input  logic [miadj_pkg::DET_W-1:0]  i_den,
    output logic                         o_done,
    output logic [miadj_pkg::OUT_W-1:0]  o_quot
);
    import miadj_pkg::*;

    localparam int CNT_W = $clog2(OUT_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [OUT_W-1:0] r_num;
    logic [OUT_W-1:0] r_quot;
    logic [DET_W-1:0] r_rem;
    logic [DET_W-1:0] r_den;
    logic [DET_W:0]   shifted;
    logic             ge;

    assign shifted = {r_rem, r_num[OUT_W-1]};
    assign ge      = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(OUT_W - 1);
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem  <= ge ? DET_W'(shifted - {1'b0, r_den}) : shifted[DET_W-1:0];
                r_quot <= {r_quot[OUT_W-2:0], ge};
                r_num  <= r_num << 1;
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

[rtl/matrix_inverse_adjugate_3x3_unit.sv]
// Top level of the 3x3 adjugate inverse unit: loader, cofactor sequencer, output stage.
// Depends on miadj_pkg, miadj_ram and miadj_div.
//
//   channel | valid       | stall       | payload
//   input   | i_in_valid  | o_in_stall  | i_element
//   output  | o_out_valid | i_out_stall | o_inverse_value, o_row_index, o_col_index,
//           |             |             | o_det_value, o_singular, o_last_of_run
//
// Loading accepts one element per cycle; the ninth starts a pass per cofactor,
// sequenced around one read port of the matrix memory. Each result is then read from
// the adjugate memory and, unless singular, divided in the bit-serial divider.
// Reset clears the load count, the determinant and all control; memories keep contents.
// Input is stalled outside loading; a stalled result holds and halts the sequencer.
module matrix_inverse_adjugate_3x3_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [miadj_pkg::ELEM_W-1:0] i_element,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [miadj_pkg::OUT_W-1:0] o_inverse_value,
    output logic [1:0]                         o_row_index,
    output logic [1:0]                         o_col_index,
    output logic signed [miadj_pkg::OUT_W-1:0] o_det_value,
    output logic                               o_singular,
    output logic                               o_last_of_run
);
    import miadj_pkg::*;

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_CALC  = 3'd1;
    localparam logic [2:0] S_ORD   = 3'd2;
    localparam logic [2:0] S_OCAP  = 3'd3;
    localparam logic [2:0] S_ODIV  = 3'd4;
    localparam logic [2:0] S_OHOLD = 3'd5;

    logic [2:0]                r_state;
    t_idx                      r_count;
    logic [3:0]                r_step;
    t_rc                       r_row;
    t_rc                       r_col;
    logic signed [ELEM_W-1:0]  r_a, r_b, r_c, r_d;
    logic signed [31:0]        r_prod, r_minor;
    logic signed [ADJ_W-1:0]   r_cof;
    logic signed [OUT_W-1:0]   r_dprod;
    logic signed [DET_W-1:0]   r_det;
    logic                      r_neg;
    logic                      r_out_valid;
    logic [OUT_W-1:0]          r_inv;

    logic                      accept_in;
    t_rc                       r1, r2, c1, c2;
    t_idx                      m_raddr;
    logic [ELEM_W-1:0]         m_rdata;
    logic signed [ADJ_W-1:0]   diff, cof;
    logic                      a_we;
    logic [ADJ_W-1:0]          a_rdata;
    logic                      singular;
    logic [ADJ_W-1:0]          adj_mag;
    logic [OUT_W-1:0]          num_mag;
    logic [DET_W-1:0]          det_mag;
    logic                      div_start, div_done;
    logic [OUT_W-1:0]          quot;
    logic                      last_idx;

    assign o_in_stall = (r_state != S_LOAD);
    assign accept_in  = i_in_valid && !o_in_stall;

    assign r1 = f_lo(r_col);
    assign r2 = f_hi(r_col);
    assign c1 = f_lo(r_row);
    assign c2 = f_hi(r_row);

    always_comb begin
        case (r_step)
            4'd0:    m_raddr = f_addr(r1, c1);
            4'd1:    m_raddr = f_addr(r2, c2);
            4'd2:    m_raddr = f_addr(r1, c2);
            4'd3:    m_raddr = f_addr(r2, c1);
            default: m_raddr = f_addr(2'd0, r_row);
        endcase
    end

    assign diff = {r_minor[31], r_minor} - {r_prod[31], r_prod};
    assign cof  = (r_row[0] ^ r_col[0]) ? -diff : diff;
    assign a_we = (r_state == S_CALC) && (r_step == 4'd7);

    miadj_ram #(.WIDTH(ELEM_W), .DEPTH(NELEM)) u_matrix_ram (
        .i_clk   (i_clk),
        .i_we    (accept_in),
        .i_waddr (r_count),
        .i_wdata (i_element),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    miadj_ram #(.WIDTH(ADJ_W), .DEPTH(NELEM)) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (f_addr(r_row, r_col)),
        .i_wdata (cof),
        .i_raddr (f_addr(r_row, r_col)),
        .o_rdata (a_rdata)
    );

    assign singular  = (r_det == '0);
    assign adj_mag   = a_rdata[ADJ_W-1] ? (~a_rdata + 1'b1) : a_rdata;
    assign num_mag   = {adj_mag, {FRAC_W{1'b0}}};
    assign det_mag   = r_det[DET_W-1] ? DET_W'(-r_det) : DET_W'(r_det);
    assign div_start = (r_state == S_OCAP) && !singular;
    assign last_idx  = (r_row == 2'd2) && (r_col == 2'd2);

    miadj_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_mag),
        .i_den   (det_mag),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_step      <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_det       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (accept_in) begin
                        if (r_count == t_idx'(NELEM - 1)) begin
                            r_count <= '0;
                            r_state <= S_CALC;
                            r_step  <= '0;
                            r_row   <= '0;
                            r_col   <= '0;
                            r_det   <= '0;
                        end else begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                S_CALC: begin
                    r_step <= r_step + 1'b1;
                    case (r_step)
                        4'd1: r_a <= m_rdata;
                        4'd2: r_b <= m_rdata;
                        4'd3: r_c <= m_rdata;
                        4'd4: r_d <= m_rdata;
                        4'd5: r_prod <= 32'(r_a) * 32'(r_b);
                        4'd6: begin
                            r_minor <= r_prod;
                            r_prod  <= 32'(r_c) * 32'(r_d);
                        end
                        4'd7: r_cof <= cof;
                        4'd8: r_a <= m_rdata;
                        4'd9: r_dprod <= OUT_W'(r_a) * OUT_W'(r_cof);
                        4'd10: begin
                            if (r_col == 2'd0) begin
                                r_det <= r_det + {r_dprod[OUT_W-1], r_dprod};
                            end
                            r_step <= '0;
                            if (last_idx) begin
                                r_row   <= '0;
                                r_col   <= '0;
                                r_state <= S_ORD;
                            end else if (r_col == 2'd2) begin
                                r_col <= '0;
                                r_row <= r_row + 1'b1;
                            end else begin
                                r_col <= r_col + 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                S_ORD: begin
                    r_state <= S_OCAP;
                end
                S_OCAP: begin
                    r_neg <= a_rdata[ADJ_W-1] ^ r_det[DET_W-1];
                    if (singular) begin
                        r_inv       <= '0;
                        r_out_valid <= 1'b1;
                        r_state     <= S_OHOLD;
                    end else begin
                        r_state <= S_ODIV;
                    end
                end
                S_ODIV: begin
                    if (div_done) begin
                        r_inv       <= r_neg ? (~quot + 1'b1) : quot;
                        r_out_valid <= 1'b1;
                        r_state     <= S_OHOLD;
                    end
                end
                S_OHOLD: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        if (last_idx) begin
                            r_row   <= '0;
                            r_col   <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_state <= S_ORD;
                            if (r_col == 2'd2) begin
                                r_col <= '0;
                                r_row <= r_row + 1'b1;
                            end else begin
                                r_col <= r_col + 1'b1;
                            end
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_inverse_value = r_inv;
    assign o_row_index     = r_row;
    assign o_col_index     = r_col;
    assign o_det_value     = singular ? '0 : r_det[OUT_W-1:0];
    assign o_singular      = singular;
    assign o_last_of_run   = last_idx;

    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("Input accepted while a result is pending.");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_singular) |-> (o_inverse_value == '0 && o_det_value == '0))
        else $error("Singular result carries nonzero values.");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_of_run) |-> (o_row_index == 2'd2 && o_col_index == 2'd2))
        else $error("Last item flag at the wrong position.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_idx'(NELEM - 1))
        else $error("Load count out of range.");

    a_div_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_ODIV))
        else $error("Divider finished outside its wait state.");
endmodule
